// ----- src/ppd_pkg.sv -----
// ---------------------------------------------------------------------------
// ppd_pkg: shared types and constants
// Codes, widths and the controller/datapath command words.
// ---------------------------------------------------------------------------
package ppd_pkg;

   localparam int Q_W     = 32;   // Q16.16 word
   localparam int MUL_W   = 34;   // multiplier operand (33-bit diff + sign)
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 50;   // residual accumulator
   localparam int DIF_W   = 33;   // point minus vertex
   localparam int SQ_W    = 66;   // sum of three squares
   localparam int ROOT_W  = 33;
   localparam int REM_W   = 37;   // square root remainder
   localparam int NUM_W   = 49;   // divider numerator
   localparam int DREM_W  = 34;   // divider remainder
   localparam int STEP_W  = 6;
   localparam int OID_W   = 3;
   localparam int OCNT_W  = 4;

   localparam int MAX_RESULTS = 8;

   localparam logic [STEP_W-1:0] SQ_LAST = 6'd32;  // 33 root bits
   localparam logic [STEP_W-1:0] DV_LAST = 6'd48;  // 49 quotient bits

   localparam logic signed [Q_W-1:0] Q_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN    = 32'sh8000_0000;
   localparam logic signed [Q_W-1:0] FACE_TOL = 32'sd6;

   localparam logic [1:0] KIND_PLANE  = 2'd0;
   localparam logic [1:0] KIND_VERTEX = 2'd1;
   localparam logic [1:0] KIND_COUNT  = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef enum logic [1:0] {
      CASE_INSIDE = 2'd0,
      CASE_FACE   = 2'd1,
      CASE_VERTEX = 2'd2
   } case_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_OBS_INIT,
      OP_PL_MX,
      OP_PL_MY,
      OP_PL_MZ,
      OP_PL_ACC,
      OP_PL_EVAL,
      OP_RES_PLANE,
      OP_PJ_MX,
      OP_PJ_MY,
      OP_PJ_MZ,
      OP_PJ_END,
      OP_V_DIFF,
      OP_V_MA,
      OP_V_MB,
      OP_V_MC,
      OP_V_ACC,
      OP_V_CMP,
      OP_RES_NOVTX,
      OP_SQ_INIT,
      OP_SQ_STEP,
      OP_RES_DIST,
      OP_DV_INIT,
      OP_DV_STEP,
      OP_DV_DONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       pass2;   // residuals taken at the projected point
      logic [1:0] comp;    // direction component being divided
   } dp_cmd_type;

   typedef struct packed {
      logic rmax_pos;      // worst residual above zero
      logic violated;      // some plane beyond tolerance at projection
   } dp_stat_type;

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [Q_W-1:0] r;
      if (x > ACC_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (x < ACC_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = x[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/ppd_dp.sv -----
// ---------------------------------------------------------------------------
// ppd_dp: distance datapath
// Table memories, shared multiplier, residual accumulator, serial sqrt/divide.
// ---------------------------------------------------------------------------
module ppd_dp #(
   parameter int MAX_OBSTACLES         = 8,
   parameter int PLANES                = 32,
   parameter int VERTICES_PER_OBSTACLE = 128,
   localparam int PL_W  = $clog2(PLANES),
   localparam int VX_W  = $clog2(VERTICES_PER_OBSTACLE),
   localparam int CNT_W = $clog2(VERTICES_PER_OBSTACLE + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_fire,
   input  logic [1:0]                  req_kind,
   input  logic [2:0]                  req_obstacle,
   input  logic [7:0]                  req_slot,
   input  logic signed [31:0]          req_coord_x,
   input  logic signed [31:0]          req_coord_y,
   input  logic signed [31:0]          req_coord_z,
   input  logic signed [31:0]          req_plane_bias,
   input  ppd_pkg::dp_cmd_type         cmd,
   input  logic [2:0]                  obs_idx,
   input  logic [PL_W-1:0]             pl_idx,
   input  logic [VX_W-1:0]             vx_idx,
   output ppd_pkg::dp_stat_type        stat,
   output logic [CNT_W-1:0]            vcount,
   output logic signed [31:0]          res_distance,
   output logic signed [31:0]          res_dir_x,
   output logic signed [31:0]          res_dir_y,
   output logic signed [31:0]          res_dir_z
);
   import ppd_pkg::*;

   localparam int OBS_W    = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int PL_DEPTH = MAX_OBSTACLES * PLANES;
   localparam int VT_DEPTH = MAX_OBSTACLES * VERTICES_PER_OBSTACLE;
   localparam int PA_W     = (PL_DEPTH > 1) ? $clog2(PL_DEPTH) : 1;
   localparam int VA_W     = (VT_DEPTH > 1) ? $clog2(VT_DEPTH) : 1;

   // tables
   logic [4*Q_W-1:0] pl_mem [PL_DEPTH];
   logic [3*Q_W-1:0] vt_mem [VT_DEPTH];
   logic [4*Q_W-1:0] pl_rd_ff;
   logic [3*Q_W-1:0] vt_rd_ff;
   logic [CNT_W-1:0] vc_ff [MAX_OBSTACLES];

   logic             obs_ok, pl_we, vt_we, vc_we;
   logic [PA_W-1:0]  pl_wa, pl_ra;
   logic [VA_W-1:0]  vt_wa, vt_ra;
   logic [CNT_W-1:0] vc_wd;

   assign obs_ok = 32'(req_obstacle) < 32'(MAX_OBSTACLES);
   assign pl_we  = req_fire && (req_kind == KIND_PLANE) && obs_ok
                   && (32'(req_slot) < 32'(PLANES));
   assign vt_we  = req_fire && (req_kind == KIND_VERTEX) && obs_ok
                   && (32'(req_slot) < 32'(VERTICES_PER_OBSTACLE));
   assign vc_we  = req_fire && (req_kind == KIND_COUNT) && obs_ok;
   assign vc_wd  = (32'(req_slot) < 32'(VERTICES_PER_OBSTACLE)) ?
                   CNT_W'(req_slot) : CNT_W'(VERTICES_PER_OBSTACLE);

   assign pl_wa = PA_W'(32'(req_obstacle) * 32'(PLANES) + 32'(req_slot));
   assign pl_ra = PA_W'(32'(obs_idx) * 32'(PLANES) + 32'(pl_idx));
   assign vt_wa = VA_W'(32'(req_obstacle) * 32'(VERTICES_PER_OBSTACLE) + 32'(req_slot));
   assign vt_ra = VA_W'(32'(obs_idx) * 32'(VERTICES_PER_OBSTACLE) + 32'(vx_idx));

   always_ff @(posedge clock) begin
      if (pl_we) begin
         pl_mem[pl_wa] <= {req_coord_x, req_coord_y, req_coord_z, req_plane_bias};
      end
      pl_rd_ff <= pl_mem[pl_ra];
   end

   always_ff @(posedge clock) begin
      if (vt_we) begin
         vt_mem[vt_wa] <= {req_coord_x, req_coord_y, req_coord_z};
      end
      vt_rd_ff <= vt_mem[vt_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_OBSTACLES; i++) begin
            vc_ff[i] <= '0;
         end
      end else if (vc_we) begin
         vc_ff[OBS_W'(req_obstacle)] <= vc_wd;
      end
   end

   assign vcount = vc_ff[OBS_W'(obs_idx)];

   // table fields
   logic signed [Q_W-1:0] nx, ny, nz, nb, vx, vy, vz;
   assign nx = pl_rd_ff[4*Q_W-1:3*Q_W];
   assign ny = pl_rd_ff[3*Q_W-1:2*Q_W];
   assign nz = pl_rd_ff[2*Q_W-1:Q_W];
   assign nb = pl_rd_ff[Q_W-1:0];
   assign vx = vt_rd_ff[3*Q_W-1:2*Q_W];
   assign vy = vt_rd_ff[2*Q_W-1:Q_W];
   assign vz = vt_rd_ff[Q_W-1:0];

   // working registers
   logic signed [Q_W-1:0]    p_x_ff, p_y_ff, p_z_ff, q_x_ff, q_y_ff, q_z_ff;
   logic signed [Q_W-1:0]    rmax_ff, nb_x_ff, nb_y_ff, nb_z_ff;
   logic                     found_ff, viol_ff, have_ff, neg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [DIF_W-1:0]  d_x_ff, d_y_ff, d_z_ff, be_x_ff, be_y_ff, be_z_ff;
   logic [SQ_W-1:0]          sq_ff, bsq_ff, rad_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [NUM_W-1:0]         num_ff, quo_ff;
   logic [DREM_W-1:0]        drem_ff;
   logic signed [Q_W-1:0]    res_d_ff, res_x_ff, res_y_ff, res_z_ff;

   // point for the residual pass
   logic signed [Q_W-1:0] pt_x, pt_y, pt_z;
   assign pt_x = cmd.pass2 ? q_x_ff : p_x_ff;
   assign pt_y = cmd.pass2 ? q_y_ff : p_y_ff;
   assign pt_z = cmd.pass2 ? q_z_ff : p_z_ff;

   // multiplier operand select
   logic signed [MUL_W-1:0] mul_a, mul_b;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_PL_MX: begin mul_a = MUL_W'(nx);      mul_b = MUL_W'(pt_x);    end
         OP_PL_MY: begin mul_a = MUL_W'(ny);      mul_b = MUL_W'(pt_y);    end
         OP_PL_MZ: begin mul_a = MUL_W'(nz);      mul_b = MUL_W'(pt_z);    end
         OP_PJ_MX: begin mul_a = MUL_W'(rmax_ff); mul_b = MUL_W'(nb_x_ff); end
         OP_PJ_MY: begin mul_a = MUL_W'(rmax_ff); mul_b = MUL_W'(nb_y_ff); end
         OP_PJ_MZ: begin mul_a = MUL_W'(rmax_ff); mul_b = MUL_W'(nb_z_ff); end
         OP_V_MA:  begin mul_a = MUL_W'(d_x_ff);  mul_b = MUL_W'(d_x_ff);  end
         OP_V_MB:  begin mul_a = MUL_W'(d_y_ff);  mul_b = MUL_W'(d_y_ff);  end
         OP_V_MC:  begin mul_a = MUL_W'(d_z_ff);  mul_b = MUL_W'(d_z_ff);  end
         default:  begin mul_a = '0;              mul_b = '0;              end
      endcase
   end

   // round to nearest, ties up (floor of x + half)
   logic signed [PROD_W-1:0] rnd_full;
   logic signed [ACC_W-1:0]  rnd_s;
   logic signed [Q_W-1:0]    resid;
   logic                     used;
   assign rnd_full = (prod_ff + 68'sd32768) >>> 16;
   assign rnd_s    = rnd_full[ACC_W-1:0];
   assign resid    = sat32(acc_ff - ACC_W'(nb));
   assign used     = (nx != '0) || (ny != '0) || (nz != '0);

   // sqrt step
   logic [REM_W-1:0] rem_sh, trial;
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[SQ_W-1:SQ_W-2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   // divide step and finish
   logic [DREM_W-1:0]     dr_sh;
   logic [DIF_W-1:0]      dv_src;
   logic                  dv_neg;
   logic [DIF_W-1:0]      dv_mag;
   logic [Q_W-1:0]        dv_q;
   logic signed [Q_W-1:0] dv_dir;
   assign dr_sh = {drem_ff[DREM_W-2:0], num_ff[NUM_W-1]};

   always_comb begin
      case (cmd.comp)
         COMP_X:  dv_src = be_x_ff;
         COMP_Y:  dv_src = be_y_ff;
         default: dv_src = be_z_ff;
      endcase
      dv_neg = dv_src[DIF_W-1];
      dv_mag = dv_neg ? (~dv_src + 1'b1) : dv_src;
      if (root_ff == '0) begin
         dv_q = '0;
      end else if (quo_ff > NUM_W'(Q_MAX)) begin
         dv_q = Q_MAX;
      end else begin
         dv_q = quo_ff[Q_W-1:0];
      end
      dv_dir = neg_ff ? -signed'(dv_q) : signed'(dv_q);
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_kind == KIND_QUERY)) begin
         p_x_ff <= req_coord_x;
         p_y_ff <= req_coord_y;
         p_z_ff <= req_coord_z;
      end
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         found_ff <= 1'b0;
         viol_ff  <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         case (cmd.op)
            OP_OBS_INIT: begin
               found_ff <= 1'b0;
               viol_ff  <= 1'b0;
               have_ff  <= 1'b0;
               rmax_ff  <= Q_MIN;
               nb_x_ff  <= '0;
               nb_y_ff  <= '0;
               nb_z_ff  <= '0;
            end
            OP_PL_MY:  acc_ff <= rnd_s;
            OP_PL_MZ:  acc_ff <= acc_ff + rnd_s;
            OP_PL_ACC: acc_ff <= acc_ff + rnd_s;
            OP_PL_EVAL: begin
               if (cmd.pass2) begin
                  if (used && (resid > FACE_TOL)) begin
                     viol_ff <= 1'b1;
                  end
               end else if (used && (!found_ff || (resid > rmax_ff))) begin
                  found_ff <= 1'b1;
                  rmax_ff  <= resid;
                  nb_x_ff  <= nx;
                  nb_y_ff  <= ny;
                  nb_z_ff  <= nz;
               end
            end
            OP_RES_PLANE: begin
               res_d_ff <= rmax_ff;
               res_x_ff <= nb_x_ff;
               res_y_ff <= nb_y_ff;
               res_z_ff <= nb_z_ff;
            end
            OP_PJ_MX:  viol_ff <= 1'b0;
            OP_PJ_MY:  q_x_ff  <= sat32(ACC_W'(p_x_ff) - rnd_s);
            OP_PJ_MZ:  q_y_ff  <= sat32(ACC_W'(p_y_ff) - rnd_s);
            OP_PJ_END: q_z_ff  <= sat32(ACC_W'(p_z_ff) - rnd_s);
            OP_V_DIFF: begin
               d_x_ff <= DIF_W'(p_x_ff) - DIF_W'(vx);
               d_y_ff <= DIF_W'(p_y_ff) - DIF_W'(vy);
               d_z_ff <= DIF_W'(p_z_ff) - DIF_W'(vz);
            end
            OP_V_MB:  sq_ff <= SQ_W'(prod_ff[SQ_W-2:0]);
            OP_V_MC:  sq_ff <= sq_ff + SQ_W'(prod_ff[SQ_W-2:0]);
            OP_V_ACC: sq_ff <= sq_ff + SQ_W'(prod_ff[SQ_W-2:0]);
            OP_V_CMP: begin
               if (!have_ff || (sq_ff < bsq_ff)) begin
                  have_ff <= 1'b1;
                  bsq_ff  <= sq_ff;
                  be_x_ff <= d_x_ff;
                  be_y_ff <= d_y_ff;
                  be_z_ff <= d_z_ff;
               end
            end
            OP_RES_NOVTX: begin
               res_d_ff <= Q_MAX;
               res_x_ff <= '0;
               res_y_ff <= '0;
               res_z_ff <= '0;
            end
            OP_SQ_INIT: begin
               rad_ff  <= bsq_ff;
               root_ff <= '0;
               rem_ff  <= '0;
            end
            OP_SQ_STEP: begin
               rad_ff <= {rad_ff[SQ_W-3:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
            end
            OP_RES_DIST: begin
               res_d_ff <= (root_ff > ROOT_W'(Q_MAX)) ? Q_MAX : root_ff[Q_W-1:0];
            end
            OP_DV_INIT: begin
               num_ff  <= (NUM_W'(dv_mag) << 16) + NUM_W'(root_ff >> 1);
               quo_ff  <= '0;
               drem_ff <= '0;
               neg_ff  <= dv_neg;
            end
            OP_DV_STEP: begin
               num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               if (dr_sh >= DREM_W'(root_ff)) begin
                  drem_ff <= dr_sh - DREM_W'(root_ff);
                  quo_ff  <= {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  drem_ff <= dr_sh;
                  quo_ff  <= {quo_ff[NUM_W-2:0], 1'b0};
               end
            end
            OP_DV_DONE: begin
               case (cmd.comp)
                  COMP_X:  res_x_ff <= dv_dir;
                  COMP_Y:  res_y_ff <= dv_dir;
                  default: res_z_ff <= dv_dir;
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   assign stat.rmax_pos = rmax_ff > 32'sd0;
   assign stat.violated = viol_ff;

   assign res_distance = res_d_ff;
   assign res_dir_x    = res_x_ff;
   assign res_dir_y    = res_y_ff;
   assign res_dir_z    = res_z_ff;

endmodule

// ----- src/ppd_ctrl.sv -----
// ---------------------------------------------------------------------------
// ppd_ctrl: query sequencer
// Walks obstacles, plane passes, vertices, sqrt and divide; issues commands.
// ---------------------------------------------------------------------------
module ppd_ctrl #(
   parameter int MAX_OBSTACLES         = 8,
   parameter int PLANES                = 32,
   parameter int VERTICES_PER_OBSTACLE = 128,
   localparam int PL_W  = $clog2(PLANES),
   localparam int VX_W  = $clog2(VERTICES_PER_OBSTACLE),
   localparam int CNT_W = $clog2(VERTICES_PER_OBSTACLE + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_kind,
   input  logic                 csr_we,
   input  logic [3:0]           csr_wdata,
   input  ppd_pkg::dp_stat_type stat,
   input  logic [CNT_W-1:0]     vcount,
   output ppd_pkg::dp_cmd_type  cmd,
   output logic [2:0]           obs_idx,
   output logic [PL_W-1:0]      pl_idx,
   output logic [VX_W-1:0]      vx_idx,
   output logic                 busy,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_obstacle_id,
   output logic [1:0]           rsp_case_code,
   output logic                 rsp_last
);
   import ppd_pkg::*;

   localparam int N_LIM = (MAX_OBSTACLES < MAX_RESULTS) ? MAX_OBSTACLES : MAX_RESULTS;

   typedef enum logic [4:0] {
      S_IDLE, S_OBS,
      S_PRD, S_PMX, S_PMY, S_PMZ, S_PACC, S_PEVAL,
      S_DEC1, S_PJX, S_PJY, S_PJZ, S_PJE, S_DEC2,
      S_VINI, S_VRD, S_VD, S_VMA, S_VMB, S_VMC, S_VACC, S_VCMP,
      S_SQI, S_SQ, S_SQE, S_DVI, S_DV, S_DVE,
      S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [OCNT_W-1:0]  ocnt_ff;
   logic [OID_W-1:0]   o_ff, o_in;
   logic [PL_W-1:0]    p_ff, p_in;
   logic [CNT_W-1:0]   v_ff, v_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]         comp_ff, comp_in;
   logic               pass2_ff, pass2_in;
   case_type           code_ff, code_in;
   logic [OCNT_W-1:0]  n_sat;
   logic               fire, last;

   assign n_sat = (32'(ocnt_ff) > 32'(N_LIM)) ? OCNT_W'(N_LIM) : ocnt_ff;
   assign fire  = start && !busy;
   assign last  = (OCNT_W'(o_ff) + 1'b1) == n_sat;

   always_comb begin
      state_in  = state_ff;
      o_in      = o_ff;
      p_in      = p_ff;
      v_in      = v_ff;
      step_in   = step_ff;
      comp_in   = comp_ff;
      pass2_in  = pass2_ff;
      code_in   = code_ff;
      cmd.op    = OP_NOP;
      cmd.pass2 = pass2_ff;
      cmd.comp  = comp_ff;
      case (state_ff)
         S_IDLE: begin
            if (fire && (req_kind == KIND_QUERY) && (n_sat != '0)) begin
               o_in     = '0;
               state_in = S_OBS;
            end
         end
         S_OBS: begin
            cmd.op   = OP_OBS_INIT;
            p_in     = '0;
            pass2_in = 1'b0;
            state_in = S_PRD;
         end
         S_PRD:  state_in = S_PMX;
         S_PMX:  begin cmd.op = OP_PL_MX;  state_in = S_PMY;   end
         S_PMY:  begin cmd.op = OP_PL_MY;  state_in = S_PMZ;   end
         S_PMZ:  begin cmd.op = OP_PL_MZ;  state_in = S_PACC;  end
         S_PACC: begin cmd.op = OP_PL_ACC; state_in = S_PEVAL; end
         S_PEVAL: begin
            cmd.op = OP_PL_EVAL;
            if (p_ff == PL_W'(PLANES - 1)) begin
               state_in = pass2_ff ? S_DEC2 : S_DEC1;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = S_PRD;
            end
         end
         S_DEC1: begin
            if (stat.rmax_pos) begin
               state_in = S_PJX;
            end else begin
               cmd.op   = OP_RES_PLANE;
               code_in  = CASE_INSIDE;
               state_in = S_OUT;
            end
         end
         S_PJX: begin cmd.op = OP_PJ_MX; state_in = S_PJY; end
         S_PJY: begin cmd.op = OP_PJ_MY; state_in = S_PJZ; end
         S_PJZ: begin cmd.op = OP_PJ_MZ; state_in = S_PJE; end
         S_PJE: begin
            cmd.op   = OP_PJ_END;
            p_in     = '0;
            pass2_in = 1'b1;
            state_in = S_PRD;
         end
         S_DEC2: begin
            if (!stat.violated) begin
               cmd.op   = OP_RES_PLANE;
               code_in  = CASE_FACE;
               state_in = S_OUT;
            end else begin
               state_in = S_VINI;
            end
         end
         S_VINI: begin
            code_in = CASE_VERTEX;
            v_in    = '0;
            if (vcount == '0) begin
               cmd.op   = OP_RES_NOVTX;
               state_in = S_OUT;
            end else begin
               state_in = S_VRD;
            end
         end
         S_VRD:  state_in = S_VD;
         S_VD:   begin cmd.op = OP_V_DIFF; state_in = S_VMA;  end
         S_VMA:  begin cmd.op = OP_V_MA;   state_in = S_VMB;  end
         S_VMB:  begin cmd.op = OP_V_MB;   state_in = S_VMC;  end
         S_VMC:  begin cmd.op = OP_V_MC;   state_in = S_VACC; end
         S_VACC: begin cmd.op = OP_V_ACC;  state_in = S_VCMP; end
         S_VCMP: begin
            cmd.op = OP_V_CMP;
            if ((v_ff + 1'b1) == vcount) begin
               state_in = S_SQI;
            end else begin
               v_in     = v_ff + 1'b1;
               state_in = S_VRD;
            end
         end
         S_SQI: begin
            cmd.op   = OP_SQ_INIT;
            step_in  = SQ_LAST;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = OP_SQ_STEP;
            if (step_ff == '0) begin
               state_in = S_SQE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_SQE: begin
            cmd.op   = OP_RES_DIST;
            comp_in  = COMP_X;
            state_in = S_DVI;
         end
         S_DVI: begin
            cmd.op   = OP_DV_INIT;
            step_in  = DV_LAST;
            state_in = S_DV;
         end
         S_DV: begin
            cmd.op = OP_DV_STEP;
            if (step_ff == '0) begin
               state_in = S_DVE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_DVE: begin
            cmd.op = OP_DV_DONE;
            if (comp_ff == COMP_Z) begin
               state_in = S_OUT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_DVI;
            end
         end
         S_OUT: begin
            if (last) begin
               state_in = S_IDLE;
            end else begin
               o_in     = o_ff + 1'b1;
               state_in = S_OBS;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ocnt_ff  <= '0;
         o_ff     <= '0;
         p_ff     <= '0;
         v_ff     <= '0;
         step_ff  <= '0;
         comp_ff  <= COMP_X;
         pass2_ff <= 1'b0;
         code_ff  <= CASE_INSIDE;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            ocnt_ff <= csr_wdata;
         end
         o_ff     <= o_in;
         p_ff     <= p_in;
         v_ff     <= v_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
         pass2_ff <= pass2_in;
         code_ff  <= code_in;
      end
   end

   assign obs_idx         = o_ff;
   assign pl_idx          = p_ff;
   assign vx_idx          = v_ff[VX_W-1:0];
   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = state_ff == S_OUT;
   assign rsp_obstacle_id = o_ff;
   assign rsp_case_code   = code_ff;
   assign rsp_last        = last;

endmodule

// ----- src/point_polytope_distance_core.sv -----
// ---------------------------------------------------------------------------
// point_polytope_distance_core: point to convex obstacle signed distance
// Plane and vertex tables per obstacle; a query word returns one result
// word per obstacle with distance, gradient direction and case code.
// ---------------------------------------------------------------------------
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  request  | start / busy      | req_kind, req_obstacle, req_slot,
//           |                   | req_coord_x/y/z, req_plane_bias
//  response | rsp_valid strobe  | rsp_obstacle_id, rsp_distance, rsp_dir_x/y/z,
//           |                   | rsp_case_code, rsp_last
//  csr      | csr_we            | csr_wdata (obstacle count)
//
// Load words (plane, vertex, count) are taken while idle; busy stays low.
// A query takes, per obstacle, a residual pass over all planes (one
// shared 34x34 multiplier, three products per plane), a second pass over
// all planes after a projection step if the worst residual is positive,
// and a vertex search, a serial square root and three serial divides if the
// projected point leaves the polytope; plus obstacle overhead (setup, two
// decisions, vertex setup, result strobe). Results leave one per obstacle,
// each strobed for one cycle; the receiver cannot stall them. Reset is
// synchronous, active high, clears the controller, the obstacle count and
// the vertex counts; tables are undefined.
// ---------------------------------------------------------------------------
module point_polytope_distance_core #(
   parameter int MAX_OBSTACLES         = 8,
   parameter int PLANES                = 32,
   parameter int VERTICES_PER_OBSTACLE = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_obstacle,
   input  logic [7:0]         req_slot,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic signed [31:0] req_plane_bias,
   output logic               rsp_valid,
   output logic [2:0]         rsp_obstacle_id,
   output logic signed [31:0] rsp_distance,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic signed [31:0] rsp_dir_z,
   output logic [1:0]         rsp_case_code,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [3:0]         csr_wdata
);
   import ppd_pkg::*;

   localparam int PL_W  = $clog2(PLANES);
   localparam int VX_W  = $clog2(VERTICES_PER_OBSTACLE);
   localparam int CNT_W = $clog2(VERTICES_PER_OBSTACLE + 1);

   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [2:0]       obs_idx;
   logic [PL_W-1:0]  pl_idx;
   logic [VX_W-1:0]  vx_idx;
   logic [CNT_W-1:0] vcount;
   logic             req_fire;

   // a word is taken whenever start meets an idle core
   assign req_fire = start && !busy;

   ppd_ctrl #(
      .MAX_OBSTACLES         (MAX_OBSTACLES),
      .PLANES                (PLANES),
      .VERTICES_PER_OBSTACLE (VERTICES_PER_OBSTACLE)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_kind        (req_kind),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .stat            (stat),
      .vcount          (vcount),
      .cmd             (cmd),
      .obs_idx         (obs_idx),
      .pl_idx          (pl_idx),
      .vx_idx          (vx_idx),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_obstacle_id (rsp_obstacle_id),
      .rsp_case_code   (rsp_case_code),
      .rsp_last        (rsp_last)
   );

   ppd_dp #(
      .MAX_OBSTACLES         (MAX_OBSTACLES),
      .PLANES                (PLANES),
      .VERTICES_PER_OBSTACLE (VERTICES_PER_OBSTACLE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_kind       (req_kind),
      .req_obstacle   (req_obstacle),
      .req_slot       (req_slot),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_plane_bias (req_plane_bias),
      .cmd            (cmd),
      .obs_idx        (obs_idx),
      .pl_idx         (pl_idx),
      .vx_idx         (vx_idx),
      .stat           (stat),
      .vcount         (vcount),
      .res_distance   (rsp_distance),
      .res_dir_x      (rsp_dir_x),
      .res_dir_y      (rsp_dir_y),
      .res_dir_z      (rsp_dir_z)
   );

   // results only appear inside a query
   a_rsp_in_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a query");

   // each result word is a single-cycle strobe
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // the final word of a query returns the core to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("core still busy after last result");

endmodule
